/* hw/rtl/nggp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// nggp_pkg
// Shared types, character codes and constant tables of the GGA position
// parser: the job that leaves the byte parser and the converted result.
// ============================================================================
package nggp_pkg;

    localparam int FRAC_DIGITS_DEF = 5;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    localparam logic [2:0] FIELD_TAG  = 3'd0;
    localparam logic [2:0] FIELD_LAT  = 3'd2;
    localparam logic [2:0] FIELD_NS   = 3'd3;
    localparam logic [2:0] FIELD_LON  = 3'd4;
    localparam logic [2:0] FIELD_EW   = 3'd5;
    localparam logic [2:0] FIELD_LAST = 3'd7;

    localparam logic [2:0] TAG_LEN  = 3'd6;
    localparam logic [2:0] TAG_FAIL = 3'd7;

    localparam logic [33:0] ACC_MAX = 34'h3_FFFF_FFFF;
    localparam logic [30:0] LAT_MAX = 31'd900000000;
    localparam logic [30:0] LON_MAX = 31'd1800000000;

    localparam logic [23:0] POW10_0 = 24'd1;
    localparam logic [23:0] POW10_1 = 24'd10;
    localparam logic [23:0] POW10_2 = 24'd100;
    localparam logic [23:0] POW10_3 = 24'd1000;
    localparam logic [23:0] POW10_4 = 24'd10000;
    localparam logic [23:0] POW10_5 = 24'd100000;
    localparam logic [23:0] POW10_6 = 24'd1000000;
    localparam logic [23:0] POW10_7 = 24'd10000000;

    // Largest accumulator that still fits 34 bits after scaling by 10^m.
    localparam logic [33:0] ACC_LIM_0 = ACC_MAX;
    localparam logic [33:0] ACC_LIM_1 = ACC_MAX / 34'(POW10_1);
    localparam logic [33:0] ACC_LIM_2 = ACC_MAX / 34'(POW10_2);
    localparam logic [33:0] ACC_LIM_3 = ACC_MAX / 34'(POW10_3);
    localparam logic [33:0] ACC_LIM_4 = ACC_MAX / 34'(POW10_4);
    localparam logic [33:0] ACC_LIM_5 = ACC_MAX / 34'(POW10_5);
    localparam logic [33:0] ACC_LIM_6 = ACC_MAX / 34'(POW10_6);
    localparam logic [33:0] ACC_LIM_7 = ACC_MAX / 34'(POW10_7);

    typedef struct packed {
        logic       valid;
        logic       emit;
        logic       conv;
        logic       is_lon;
        logic       tag;
        logic [1:0] seen;
        logic       acc_ovf;
        logic [1:0] hem;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [33:0] acc;
        logic [2:0]  fcnt;
    } job_t;

    typedef struct packed {
        side_t       side;
        logic        ovf;
        logic [30:0] value;
    } conv_res_t;

    function automatic logic [23:0] pow10_sel(input logic [2:0] m);
        logic [23:0] p;
        case (m)
            3'd0: p = POW10_0;
            3'd1: p = POW10_1;
            3'd2: p = POW10_2;
            3'd3: p = POW10_3;
            3'd4: p = POW10_4;
            3'd5: p = POW10_5;
            3'd6: p = POW10_6;
            3'd7: p = POW10_7;
            default: p = POW10_0;
        endcase
        return p;
    endfunction

    function automatic logic [33:0] acc_limit_sel(input logic [2:0] m);
        logic [33:0] l;
        case (m)
            3'd0: l = ACC_LIM_0;
            3'd1: l = ACC_LIM_1;
            3'd2: l = ACC_LIM_2;
            3'd3: l = ACC_LIM_3;
            3'd4: l = ACC_LIM_4;
            3'd5: l = ACC_LIM_5;
            3'd6: l = ACC_LIM_6;
            3'd7: l = ACC_LIM_7;
            default: l = ACC_LIM_0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h24;
            3'd1: c = 8'h47;
            3'd2: c = 8'h50;
            3'd3: c = 8'h47;
            3'd4: c = 8'h47;
            3'd5: c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/nmea_gga_position_parser_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// nmea_gga_position_parser_core
// NMEA GGA latitude and longitude extractor with one result per text line.
// ============================================================================
// The core takes one received character per beat, and one beat can be taken
// in every clock cycle while s_ready is high. Every line feed yields one
// result beat carrying the latitude and longitude in 1e-7 degree units with
// their hemisphere flags and a validity bit. The byte parser's job register
// loads at the accepting edge, then the nine-stage conversion pipeline and
// the result register follow. s_ready falls only while a finished result
// waits in the result register with m_ready low and the next line's result
// has already reached the end of the pipeline.
module nmea_gga_position_parser_core #(
    parameter int FRAC_DIGITS = nggp_pkg::FRAC_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_coords_valid,
    output logic [29:0] m_latitude_e7,
    output logic        m_lat_south,
    output logic [30:0] m_longitude_e7,
    output logic        m_lon_west
);
    import nggp_pkg::*;

    logic      advance;
    logic      accept;
    job_t      job;
    conv_res_t res;

    assign s_ready = advance;
    assign accept  = s_valid && advance;

    nggp_parser #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .advance (advance),
        .rx_byte (s_rx_byte),
        .job     (job)
    );

    nggp_convert #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_convert (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .job     (job),
        .res     (res)
    );

    nggp_result u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res            (res),
        .m_ready        (m_ready),
        .advance        (advance),
        .m_valid        (m_valid),
        .m_coords_valid (m_coords_valid),
        .m_latitude_e7  (m_latitude_e7),
        .m_lat_south    (m_lat_south),
        .m_longitude_e7 (m_longitude_e7),
        .m_lon_west     (m_lon_west)
    );

endmodule

/* hw/rtl/nggp_parser.sv */
`timescale 1ns / 1ps
// ============================================================================
// nggp_parser
// Byte-level field splitter: tracks the field index, matches the sentence
// tag, accumulates coordinate digits and issues conversion and line jobs.
// ============================================================================
module nggp_parser #(
    parameter int FRAC_DIGITS = nggp_pkg::FRAC_DIGITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              advance,
    input  logic [7:0]        rx_byte,
    output nggp_pkg::job_t    job
);
    import nggp_pkg::*;

    localparam logic [2:0] FRAC_MAX = 3'(FRAC_DIGITS);

    logic [2:0]  pos_reg,  pos_next;
    logic [2:0]  tidx_reg, tidx_next;
    logic        tag_reg,  tag_next;
    logic [33:0] acc_reg,  acc_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic        frac_reg, frac_next;
    logic        ovf_reg,  ovf_next;
    logic [1:0]  hem_reg,  hem_next;
    logic [1:0]  seen_reg, seen_next;
    job_t        job_reg,  job_next;

    logic        tag_after;
    logic        conv_req;
    logic        is_digit;
    logic [37:0] acc_x10;
    logic        acc_sat;

    always_comb begin
        tag_after = (pos_reg == FIELD_TAG) ? (tidx_reg == TAG_LEN) : tag_reg;
        conv_req  = tag_reg && (pos_reg == FIELD_LAT || pos_reg == FIELD_LON);
        is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        acc_x10   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                  + 38'(rx_byte - CHAR_ZERO);
        acc_sat   = acc_x10 > 38'(ACC_MAX);

        pos_next  = pos_reg;
        tidx_next = tidx_reg;
        tag_next  = tag_reg;
        acc_next  = acc_reg;
        fcnt_next = fcnt_reg;
        frac_next = frac_reg;
        ovf_next  = ovf_reg;
        hem_next  = hem_reg;
        seen_next = seen_reg;

        job_next              = '0;
        job_next.side.emit    = 1'b0;
        job_next.side.conv    = conv_req;
        job_next.side.is_lon  = (pos_reg == FIELD_LON);
        job_next.side.tag     = tag_after;
        job_next.side.seen    = seen_reg;
        job_next.side.acc_ovf = ovf_reg;
        job_next.side.hem     = hem_reg;
        job_next.acc          = acc_reg;
        job_next.fcnt         = fcnt_reg;

        if (accept) begin
            if (rx_byte == CHAR_LF) begin
                job_next.side.valid = 1'b1;
                job_next.side.emit  = 1'b1;
                pos_next  = '0;
                tidx_next = '0;
                tag_next  = 1'b0;
                acc_next  = '0;
                fcnt_next = '0;
                frac_next = 1'b0;
                ovf_next  = 1'b0;
                hem_next  = '0;
                seen_next = '0;
            end else if (rx_byte == CHAR_COMMA) begin
                job_next.side.valid = conv_req;
                tag_next  = tag_after;
                acc_next  = '0;
                fcnt_next = '0;
                frac_next = 1'b0;
                if (pos_reg != FIELD_LAST) begin
                    pos_next = pos_reg + 3'd1;
                end
            end else if (pos_reg == FIELD_TAG) begin
                if (tidx_reg < TAG_LEN && rx_byte == tag_char(tidx_reg)) begin
                    tidx_next = tidx_reg + 3'd1;
                end else begin
                    tidx_next = TAG_FAIL;
                end
            end else if (tag_reg) begin
                if (pos_reg == FIELD_LAT || pos_reg == FIELD_LON) begin
                    if (is_digit) begin
                        if (pos_reg == FIELD_LAT) begin
                            seen_next[0] = 1'b1;
                        end else begin
                            seen_next[1] = 1'b1;
                        end
                        // Fraction digits past the configured count are dropped.
                        if (!(frac_reg && fcnt_reg >= FRAC_MAX)) begin
                            if (frac_reg) begin
                                fcnt_next = fcnt_reg + 3'd1;
                            end
                            acc_next = acc_sat ? ACC_MAX : acc_x10[33:0];
                            ovf_next = ovf_reg | acc_sat;
                        end
                    end else if (rx_byte == CHAR_DOT && !frac_reg) begin
                        frac_next = 1'b1;
                    end
                end else if (pos_reg == FIELD_NS || pos_reg == FIELD_EW) begin
                    // Only the first character of a hemisphere field counts.
                    if (!frac_reg) begin
                        if (pos_reg == FIELD_NS && rx_byte == CHAR_S) begin
                            hem_next[0] = 1'b1;
                        end
                        if (pos_reg == FIELD_EW && rx_byte == CHAR_W) begin
                            hem_next[1] = 1'b1;
                        end
                        frac_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            tidx_reg <= '0;
            tag_reg  <= 1'b0;
            acc_reg  <= '0;
            fcnt_reg <= '0;
            frac_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            hem_reg  <= '0;
            seen_reg <= '0;
            job_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            tidx_reg <= tidx_next;
            tag_reg  <= tag_next;
            acc_reg  <= acc_next;
            fcnt_reg <= fcnt_next;
            frac_reg <= frac_next;
            ovf_reg  <= ovf_next;
            hem_reg  <= hem_next;
            seen_reg <= seen_next;
            if (advance) begin
                job_reg <= job_next;
            end
        end
    end

    assign job = job_reg;

endmodule

/* hw/rtl/nggp_convert.sv */
`timescale 1ns / 1ps
// ============================================================================
// nggp_convert
// Nine-stage pipeline that turns a ddmm.mmmmm accumulator into degrees in
// 1e-7 units, using reciprocal multiplies for the constant divisions.
// ============================================================================
module nggp_convert #(
    parameter int FRAC_DIGITS = nggp_pkg::FRAC_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  nggp_pkg::job_t        job,
    output nggp_pkg::conv_res_t   res
);
    import nggp_pkg::*;

    localparam logic [2:0]  FRAC_MAX  = 3'(FRAC_DIGITS);
    localparam logic [29:0] DIV_Q     = 30'(64'd100 * 64'(pow10_sel(FRAC_MAX)));
    localparam logic [24:0] RECIP_Q   = 25'((64'd1 << 34) / 64'(DIV_Q));
    localparam logic [23:0] POW_REST  = pow10_sel(3'(7 - FRAC_DIGITS));
    localparam logic [24:0] RECIP_60  = 25'((64'd1 << 30) / 64'd60);
    localparam logic [23:0] DEG_SCALE = 24'd10000000;

    side_t       s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg, s9_reg;
    logic        o1_reg, o2_reg, o3_reg, o4_reg, o5_reg, o6_reg, o7_reg, o8_reg, o9_reg;
    logic [33:0] a1_reg, a2_reg, a3_reg;
    logic [58:0] pq2_reg;
    logic [24:0] q3_reg;
    logic [33:0] qd3_reg;
    logic [24:0] whole4_reg;
    logic [29:0] part4_reg;
    logic [48:0] wp5_reg, wp6_reg, wp7_reg, wp8_reg;
    logic [29:0] x5_reg, x6_reg, x7_reg;
    logic [54:0] p606_reg;
    logic [23:0] q607_reg;
    logic [29:0] q60x7_reg;
    logic [23:0] frac8_reg;
    logic [30:0] v9_reg;

    logic [2:0]  missing;
    logic        sat1;
    logic [57:0] scaled1;
    logic [54:0] qd_full;
    logic [33:0] rem4;
    logic [53:0] x_full;
    logic [29:0] rem8;
    logic [48:0] sum9;
    logic [30:0] lim9;

    always_comb begin
        missing = (job.fcnt < FRAC_MAX) ? (FRAC_MAX - job.fcnt) : 3'd0;
        sat1    = job.acc > acc_limit_sel(missing);
        scaled1 = job.acc * pow10_sel(missing);
        qd_full = pq2_reg[58:34] * DIV_Q;
        rem4    = a3_reg - qd3_reg;
        x_full  = part4_reg * POW_REST;
        rem8    = x7_reg - q60x7_reg;
        sum9    = wp8_reg + 49'(frac8_reg);
        lim9    = s8_reg.is_lon ? LON_MAX : LAT_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
            s7_reg <= '0;
            s8_reg <= '0;
            s9_reg <= '0;
        end else if (advance) begin
            s1_reg <= job.side;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            s5_reg <= s4_reg;
            s6_reg <= s5_reg;
            s7_reg <= s6_reg;
            s8_reg <= s7_reg;
            s9_reg <= s8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            // Stage 1: pad missing fraction digits, saturating at 34 bits.
            o1_reg <= sat1;
            a1_reg <= sat1 ? ACC_MAX : scaled1[33:0];
            // Stages 2 to 4: degrees and minutes by division through 100*10^F.
            o2_reg  <= o1_reg;
            a2_reg  <= a1_reg;
            pq2_reg <= a1_reg * RECIP_Q;
            o3_reg  <= o2_reg;
            a3_reg  <= a2_reg;
            q3_reg  <= pq2_reg[58:34];
            qd3_reg <= qd_full[33:0];
            o4_reg  <= o3_reg;
            if (rem4 >= 34'(DIV_Q)) begin
                whole4_reg <= q3_reg + 25'd1;
                part4_reg  <= 30'(rem4 - 34'(DIV_Q));
            end else begin
                whole4_reg <= q3_reg;
                part4_reg  <= rem4[29:0];
            end
            // Stages 5 to 8: minutes times 1e7/(60*10^F), as x/60.
            o5_reg  <= o4_reg;
            wp5_reg <= whole4_reg * DEG_SCALE;
            x5_reg  <= x_full[29:0];
            o6_reg   <= o5_reg;
            wp6_reg  <= wp5_reg;
            x6_reg   <= x5_reg;
            p606_reg <= x5_reg * RECIP_60;
            o7_reg    <= o6_reg;
            wp7_reg   <= wp6_reg;
            x7_reg    <= x6_reg;
            q607_reg  <= p606_reg[53:30];
            q60x7_reg <= 30'(p606_reg[53:30] * 6'd60);
            o8_reg    <= o7_reg;
            wp8_reg   <= wp7_reg;
            frac8_reg <= (rem8 >= 30'd60) ? (q607_reg + 24'd1) : q607_reg;
            // Stage 9: sum and clamp to the coordinate's limit.
            o9_reg <= o8_reg;
            v9_reg <= (sum9 > 49'(lim9)) ? lim9 : sum9[30:0];
        end
    end

    always_comb begin
        res.side  = s9_reg;
        res.ovf   = o9_reg;
        res.value = v9_reg;
    end

endmodule

/* hw/rtl/nggp_result.sv */
`timescale 1ns / 1ps
// ============================================================================
// nggp_result
// Holds the converted coordinates of the current line and loads the result
// register when the line-feed job arrives.
// ============================================================================
module nggp_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nggp_pkg::conv_res_t   res,
    input  logic                  m_ready,
    output logic                  advance,
    output logic                  m_valid,
    output logic                  m_coords_valid,
    output logic [29:0]           m_latitude_e7,
    output logic                  m_lat_south,
    output logic [30:0]           m_longitude_e7,
    output logic                  m_lon_west
);
    import nggp_pkg::*;

    logic [29:0] lat_reg, lat_next;
    logic [30:0] lon_reg, lon_next;
    logic        cov_reg, cov_next;
    logic        valid_reg;
    logic        ok_reg;
    logic [29:0] olat_reg;
    logic [30:0] olon_reg;
    logic        south_reg, west_reg;
    logic        ok_next;

    // Only a line result that finds the result register still occupied, with m_ready low, stalls.
    assign advance = !(res.side.valid && res.side.emit && valid_reg && !m_ready);

    always_comb begin
        lat_next = lat_reg;
        lon_next = lon_reg;
        cov_next = cov_reg;
        if (res.side.valid && res.side.conv) begin
            cov_next = cov_reg | res.ovf;
            if (res.side.is_lon) begin
                lon_next = res.value;
            end else begin
                lat_next = res.value[29:0];
            end
        end
        ok_next = res.side.tag && (res.side.seen == 2'b11) && !res.side.acc_ovf
               && !cov_next
               && (lat_next != '0) && ({1'b0, lat_next} < LAT_MAX)
               && (lon_next != '0) && (lon_next < LON_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg   <= '0;
            lon_reg   <= '0;
            cov_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (advance && res.side.valid) begin
                if (res.side.emit) begin
                    lat_reg <= '0;
                    lon_reg <= '0;
                    cov_reg <= 1'b0;
                end else begin
                    lat_reg <= lat_next;
                    lon_reg <= lon_next;
                    cov_reg <= cov_next;
                end
            end
            if (advance && res.side.valid && res.side.emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.side.valid && res.side.emit) begin
            ok_reg    <= ok_next;
            olat_reg  <= lat_next;
            olon_reg  <= lon_next;
            south_reg <= res.side.hem[0];
            west_reg  <= res.side.hem[1];
        end
    end

    assign m_valid        = valid_reg;
    assign m_coords_valid = ok_reg;
    assign m_latitude_e7  = olat_reg;
    assign m_lat_south    = south_reg;
    assign m_longitude_e7 = olon_reg;
    assign m_lon_west     = west_reg;

endmodule
